// ===== sv/mlrq_pkg.sv =====
`default_nettype none

package mlrq_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEVELS = 3;
   localparam int LVL_W  = 2;
   localparam int CMD_W  = 3;
   localparam int STS_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC      = 3'd0,
      CMD_FREE       = 3'd1,
      CMD_MAKE_READY = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_SET_LEVEL  = 3'd4,
      CMD_PICK       = 3'd5
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_NOREADY = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_SEARCH,
      S_ENQ,
      S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_CLEAR,
      DP_ACCEPT,
      DP_ALLOC_OK,
      DP_ALLOC_NONE,
      DP_FREE,
      DP_ENQ,
      DP_UNL_HEAD,
      DP_SEARCH_START,
      DP_SEARCH_STEP,
      DP_UNL_FOUND,
      DP_SETLV,
      DP_IGNORE,
      DP_DONE_ONLY,
      DP_PICK_TAKE,
      DP_PICK_NONE,
      DP_EMIT_OP
   } dp_op_type;

   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic             in_use;
      logic             queued;
   } attr_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             slot_ok;
      logic             queued;
      logic             lvl_ok;
      logic             lvl_same;
      logic             stored_ok;
      logic             free_empty;
      logic             q_ne;
      logic             head_hit;
      logic             rd_hit;
      logic             prev_tail;
      logic             pick_any;
      logic             out_free;
      logic             clr_last;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== sv/mlrq_if.sv =====
`default_nettype none

interface mlrq_req_if #(parameter int SW = mlrq_pkg::SLOT_W) ();
   logic          valid;
   logic          ready;
   logic [2:0]    cmd;
   logic [SW-1:0] slot;
   logic [1:0]    level;
   modport source (output valid, cmd, slot, level, input ready);
   modport sink (input valid, cmd, slot, level, output ready);
endinterface

interface mlrq_rsp_if #(parameter int SW = mlrq_pkg::SLOT_W) ();
   logic          valid;
   logic          ready;
   logic [1:0]    status;
   logic [SW-1:0] out_slot;
   logic [1:0]    out_level;
   modport source (output valid, status, out_slot, out_level, input ready);
   modport sink (input valid, status, out_slot, out_level, output ready);
endinterface

interface mlrq_csr_if ();
   logic       valid;
   logic       ready;
   logic [1:0] default_level;
   modport source (output valid, default_level, input ready);
   modport sink (input valid, default_level, output ready);
endinterface

`default_nettype wire

// ===== sv/mlrq_ram.sv =====
`default_nettype none

module mlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/mlrq_ctrl.sv =====
`default_nettype none

module mlrq_ctrl import mlrq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  dp_stat_type st,
   output logic        req_ready,
   output dp_op_type   op
);

   state_type state_ff, state_in;
   logic      valid_slot, unl_path, is_setlv;
   state_type after_unl;

   assign valid_slot = st.slot_ok;
   assign is_setlv   = (cmd_type'(st.cmd) == CMD_SET_LEVEL);
   assign unl_path   = valid_slot && st.queued &&
                       ((cmd_type'(st.cmd) == CMD_REMOVE) ||
                        (is_setlv && st.lvl_ok && !st.lvl_same));
   assign after_unl  = is_setlv ? S_ENQ : S_EMIT;
   assign req_ready  = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (unl_path) begin
               if (!st.q_ne || st.head_hit) state_in = after_unl;
               else state_in = S_SEARCH;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SEARCH: begin
            if (st.rd_hit || st.prev_tail) state_in = after_unl;
         end
         S_ENQ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op = DP_NONE;
      unique case (state_ff)
         S_CLEAR: op = DP_CLEAR;
         S_IDLE: begin
            if (req_valid) op = DP_ACCEPT;
         end
         S_LOOK: begin
            case (cmd_type'(st.cmd))
               CMD_ALLOC: op = st.free_empty ? DP_ALLOC_NONE : DP_ALLOC_OK;
               CMD_FREE: op = (valid_slot && !st.queued) ? DP_FREE : DP_IGNORE;
               CMD_MAKE_READY:
                  op = (valid_slot && !st.queued && st.stored_ok) ? DP_ENQ : DP_IGNORE;
               CMD_REMOVE, CMD_SET_LEVEL: begin
                  if (unl_path) begin
                     if (!st.q_ne) op = is_setlv ? DP_NONE : DP_DONE_ONLY;
                     else if (st.head_hit) op = DP_UNL_HEAD;
                     else op = DP_SEARCH_START;
                  end else if (is_setlv && valid_slot && st.lvl_ok) begin
                     op = DP_SETLV;
                  end else begin
                     op = DP_IGNORE;
                  end
               end
               CMD_PICK: op = st.pick_any ? DP_PICK_TAKE : DP_PICK_NONE;
               default: op = DP_IGNORE;
            endcase
         end
         S_SEARCH: begin
            if (st.rd_hit) op = DP_UNL_FOUND;
            else if (st.prev_tail) op = is_setlv ? DP_NONE : DP_DONE_ONLY;
            else op = DP_SEARCH_STEP;
         end
         S_ENQ: op = DP_ENQ;
         S_EMIT: begin
            if (st.out_free) op = DP_EMIT_OP;
         end
         default: op = DP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/mlrq_dp.sv =====
`default_nettype none

module mlrq_dp import mlrq_pkg::*; #(
   parameter int SLOTS = 64,
   localparam int SW = $clog2(SLOTS),
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  dp_op_type        op,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic [SW-1:0]    req_slot,
   input  logic [LVL_W-1:0] req_level,
   input  logic             csr_we,
   input  logic [LVL_W-1:0] csr_data,
   input  logic             rsp_ready,
   output dp_stat_type      st,
   output logic             rsp_valid,
   output logic [STS_W-1:0] rsp_status,
   output logic [SW-1:0]    rsp_slot,
   output logic [LVL_W-1:0] rsp_level
);

   localparam int AW = $bits(attr_type);

   cmd_type          cmd_ff, cmd_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [LVL_W-1:0] lvin_ff, lvin_in;
   logic [LVL_W-1:0] pl_ff, pl_in;
   logic [SW-1:0]    prev_ff, prev_in;
   logic [SW-1:0]    link_s_ff, link_s_in;
   logic [SW-1:0]    free_head_ff, free_head_in;
   logic [CW-1:0]    free_count_ff, free_count_in;
   logic [LVL_W-1:0] sweep_ff, sweep_in;
   logic [SW-1:0]    qhead_ff [LEVELS];
   logic [SW-1:0]    qhead_in [LEVELS];
   logic [SW-1:0]    qtail_ff [LEVELS];
   logic [SW-1:0]    qtail_in [LEVELS];
   logic [LEVELS-1:0] qne_ff, qne_in;
   logic [LVL_W-1:0] dlvl_ff, dlvl_in;
   logic [SW-1:0]    clr_ff, clr_in;
   status_type       res_status_ff, res_status_in;
   logic [SW-1:0]    res_slot_ff, res_slot_in;
   logic [LVL_W-1:0] res_level_ff, res_level_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [LVL_W-1:0] rsp_level_ff, rsp_level_in;

   logic          link_we, link_re, attr_we, attr_re;
   logic [SW-1:0] link_waddr, link_raddr, link_wdata, link_rd;
   logic [SW-1:0] attr_waddr;
   attr_type      attr_wdata, attr_rd;

   logic [LVL_W-1:0] alv, alv_ix, dl_sat, wlv, pick_lvl, l_hi, l_any;
   logic             alv_ok, found_hi, out_free;
   logic [SW-1:0]    pick_head;

   mlrq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rd)
   );

   mlrq_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_attr_ram (
      .clock (clock),
      .we    (attr_we),
      .waddr (attr_waddr),
      .wdata (attr_wdata),
      .re    (attr_re),
      .raddr (req_slot),
      .rdata (attr_rd)
   );

   assign alv      = attr_rd.lvl;
   assign alv_ok   = (alv < LVL_W'(LEVELS));
   assign alv_ix   = alv_ok ? alv : '0;
   assign dl_sat   = (dlvl_ff >= LVL_W'(LEVELS)) ? LVL_W'(LEVELS - 1) : dlvl_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wlv      = (cmd_ff == CMD_SET_LEVEL) ? lvin_ff : alv_ix;

   always_comb begin
      found_hi = 1'b0;
      l_hi     = '0;
      l_any    = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (qne_ff[l] && (LVL_W'(l) >= sweep_ff)) begin
            found_hi = 1'b1;
            l_hi     = LVL_W'(l);
         end
         if (qne_ff[l]) begin
            l_any = LVL_W'(l);
         end
      end
   end

   assign pick_lvl  = found_hi ? l_hi : l_any;
   assign pick_head = qhead_ff[pl_ff];

   always_comb begin
      st            = '0;
      st.cmd        = cmd_ff;
      st.slot_ok    = ({1'b0, slot_ff} < (SW + 1)'(SLOTS)) && attr_rd.in_use;
      st.queued     = attr_rd.queued;
      st.lvl_ok     = (lvin_ff < LVL_W'(LEVELS));
      st.lvl_same   = (alv == lvin_ff);
      st.stored_ok  = alv_ok;
      st.free_empty = (free_count_ff == '0);
      st.q_ne       = alv_ok && qne_ff[alv_ix];
      st.head_hit   = (qhead_ff[alv_ix] == slot_ff);
      st.rd_hit     = (link_rd == slot_ff);
      st.prev_tail  = (prev_ff == qtail_ff[alv_ix]);
      st.pick_any   = |qne_ff;
      st.out_free   = out_free;
      st.clr_last   = (clr_ff == SW'(SLOTS - 1));
   end

   always_comb begin
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      lvin_in       = lvin_ff;
      pl_in         = pl_ff;
      prev_in       = prev_ff;
      link_s_in     = link_s_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      sweep_in      = sweep_ff;
      qhead_in      = qhead_ff;
      qtail_in      = qtail_ff;
      qne_in        = qne_ff;
      dlvl_in       = csr_we ? csr_data : dlvl_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_level_in  = res_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_level_in  = rsp_level_ff;
      link_we       = 1'b0;
      link_waddr    = slot_ff;
      link_wdata    = free_head_ff;
      link_re       = 1'b0;
      link_raddr    = req_slot;
      attr_we       = 1'b0;
      attr_waddr    = slot_ff;
      attr_wdata    = '{lvl: alv, in_use: 1'b1, queued: 1'b0};
      attr_re       = 1'b0;

      case (op)
         DP_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = st.clr_last ? '0 : clr_ff + SW'(1);
            attr_we    = 1'b1;
            attr_waddr = clr_ff;
            attr_wdata = '0;
            clr_in     = clr_ff + SW'(1);
         end
         DP_ACCEPT: begin
            cmd_in  = cmd_type'(req_cmd);
            slot_in = req_slot;
            lvin_in = req_level;
            pl_in   = pick_lvl;
            link_re = 1'b1;
            attr_re = 1'b1;
            if (cmd_type'(req_cmd) == CMD_ALLOC) link_raddr = free_head_ff;
            else if (cmd_type'(req_cmd) == CMD_PICK) link_raddr = qhead_ff[pick_lvl];
            else link_raddr = req_slot;
         end
         DP_ALLOC_OK: begin
            attr_we       = 1'b1;
            attr_waddr    = free_head_ff;
            attr_wdata    = '{lvl: dl_sat, in_use: 1'b1, queued: 1'b0};
            free_head_in  = link_rd;
            free_count_in = free_count_ff - CW'(1);
            res_status_in = ST_DONE;
            res_slot_in   = free_head_ff;
            res_level_in  = dl_sat;
         end
         DP_ALLOC_NONE: begin
            res_status_in = ST_NOFREE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_FREE: begin
            link_we       = 1'b1;
            free_head_in  = slot_ff;
            free_count_in = free_count_ff + CW'(1);
            attr_we       = 1'b1;
            attr_wdata    = '{lvl: alv, in_use: 1'b0, queued: 1'b0};
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_ENQ: begin
            if (qne_ff[wlv]) begin
               link_we    = 1'b1;
               link_waddr = qtail_ff[wlv];
               link_wdata = slot_ff;
            end else begin
               qhead_in[wlv] = slot_ff;
               qne_in[wlv]   = 1'b1;
            end
            qtail_in[wlv] = slot_ff;
            attr_we       = 1'b1;
            attr_wdata    = '{lvl: wlv, in_use: 1'b1, queued: 1'b1};
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_UNL_HEAD: begin
            if (qtail_ff[alv_ix] == slot_ff) qne_in[alv_ix] = 1'b0;
            else qhead_in[alv_ix] = link_rd;
            attr_we       = 1'b1;
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_SEARCH_START: begin
            prev_in    = qhead_ff[alv_ix];
            link_s_in  = link_rd;
            link_re    = 1'b1;
            link_raddr = qhead_ff[alv_ix];
         end
         DP_SEARCH_STEP: begin
            prev_in    = link_rd;
            link_re    = 1'b1;
            link_raddr = link_rd;
         end
         DP_UNL_FOUND: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = link_s_ff;
            if (qtail_ff[alv_ix] == slot_ff) qtail_in[alv_ix] = prev_ff;
            attr_we       = 1'b1;
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_SETLV: begin
            attr_we       = 1'b1;
            attr_wdata    = '{lvl: lvin_ff, in_use: 1'b1, queued: attr_rd.queued};
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_IGNORE: begin
            res_status_in = ST_IGNORED;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_DONE_ONLY: begin
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_PICK_TAKE: begin
            if (qtail_ff[pl_ff] == pick_head) qne_in[pl_ff] = 1'b0;
            else qhead_in[pl_ff] = link_rd;
            attr_we       = 1'b1;
            attr_waddr    = pick_head;
            attr_wdata    = '{lvl: pl_ff, in_use: 1'b1, queued: 1'b0};
            sweep_in      = (pl_ff == LVL_W'(LEVELS - 1)) ? '0 : pl_ff + LVL_W'(1);
            res_status_in = ST_DONE;
            res_slot_in   = pick_head;
            res_level_in  = pl_ff;
         end
         DP_PICK_NONE: begin
            sweep_in      = '0;
            res_status_in = ST_NOREADY;
            res_slot_in   = '0;
            res_level_in  = '0;
         end
         DP_EMIT_OP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_slot_in   = res_slot_ff;
            rsp_level_in  = res_level_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_count_ff <= CW'(SLOTS);
         sweep_ff      <= '0;
         qne_ff        <= '0;
         dlvl_ff       <= LVL_W'(1);
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         sweep_ff      <= sweep_in;
         qne_ff        <= qne_in;
         dlvl_ff       <= dlvl_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      lvin_ff       <= lvin_in;
      pl_ff         <= pl_in;
      prev_ff       <= prev_in;
      link_s_ff     <= link_s_in;
      qhead_ff      <= qhead_in;
      qtail_ff      <= qtail_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_level_ff  <= res_level_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_level  = rsp_level_ff;

endmodule

`default_nettype wire

// ===== sv/multilevel_ready_queue_manager_core.sv =====
// Multilevel ready-queue manager: task slots on a LIFO free list and on
// three FIFO ready queues threaded through one link memory.
// Channels: req_chan carries one command (cmd, slot, level) per transfer;
// rsp_chan returns exactly one result (status, out_slot, out_level) per
// command, in order; csr_chan writes default_level and is always ready.
// The user must write it only while no command is in flight; the block
// does not enforce this. After a command's transfer the memories are read,
// the decision loads the result register and the result then moves to
// the output register; the next command is taken after that. remove and
// set_level of a slot that is not at the head of its queue walk the queue
// through the link memory, one link per cycle, from the head until the
// slot or the tail is reached. set_level that moves a slot then adds an
// enqueue step. The link memory has a single read port, so the walk reads
// one link at a time. Throughput: one command in flight; a new command is
// taken while the previous result still waits in the output register.
// Reset: a clearing pass rebuilds the free list in the link
// memory; req_chan.ready stays low until it ends.
// A stalled receiver holds the result; the next result waits in the block
// until the output register frees, and no further command is taken.
`default_nettype none

module multilevel_ready_queue_manager_core import mlrq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mlrq_req_if.sink   req_chan,
   mlrq_rsp_if.source rsp_chan,
   mlrq_csr_if.sink   csr_chan
);

   dp_op_type   op;
   dp_stat_type st;

   assign csr_chan.ready = 1'b1;

   mlrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .st        (st),
      .req_ready (req_chan.ready),
      .op        (op)
   );

   mlrq_dp #(.SLOTS(SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_cmd    (req_chan.cmd),
      .req_slot   (req_chan.slot),
      .req_level  (req_chan.level),
      .csr_we     (csr_chan.valid),
      .csr_data   (csr_chan.default_level),
      .rsp_ready  (rsp_chan.ready),
      .st         (st),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .rsp_slot   (rsp_chan.out_slot),
      .rsp_level  (rsp_chan.out_level)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (op == DP_EMIT_OP) |-> st.out_free)
      else $error("result loaded over a pending result");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      (op == DP_ACCEPT) |-> req_chan.valid)
      else $error("command taken without a transfer");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (op == DP_ACCEPT) |=> (op != DP_ACCEPT) && (op != DP_CLEAR))
      else $error("second command taken while one is in flight");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(op == DP_EMIT_OP))
      else $error("result raised without a load");

endmodule

`default_nettype wire
